FILE: sv/rlc_pkg.sv
// rlc_pkg: shared types and constants of the run-length codec
// holds item structs, the queue command format and default sizes
// no dependencies
package rlc_pkg;

    localparam int MAX_RUN_DEFAULT     = 9;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int CNT_W               = 4;
    localparam logic [7:0] DIGIT_BASE  = 8'd48;
    localparam logic [7:0] DIGIT_TOP   = 8'd57;

    typedef struct packed {
        logic [7:0] symbol;
        logic       decode_mode;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       out_last;
    } out_item_t;

    // one segment: optional count digit, then the symbol reps times
    typedef struct packed {
        logic             valid;
        logic             digit_en;
        logic [CNT_W-1:0] digit;
        logic [7:0]       sym;
        logic [CNT_W-1:0] reps;
    } seg_t;

    // work for the back end: up to two segments, last marks the final byte
    typedef struct packed {
        seg_t seg_a;
        seg_t seg_b;
        logic last;
    } cmd_t;

endpackage

FILE: sv/rlc_front.sv
// rlc_front: accepts items, tracks encode runs and decode digits
// turns each item into at most one command for the queue
// depends on rlc_pkg
module rlc_front #(
    parameter int MAX_RUN = rlc_pkg::MAX_RUN_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  rlc_pkg::in_item_t item,
    output logic             push,
    output rlc_pkg::cmd_t    cmd
);

    localparam int CW = rlc_pkg::CNT_W;

    logic [7:0]    held_symbol_reg, held_symbol_next;
    logic [CW-1:0] run_length_reg, run_length_next;
    logic          holding_reg, holding_next;
    logic [CW-1:0] repeat_count_reg, repeat_count_next;
    logic          count_pending_reg, count_pending_next;

    logic          same_run;
    logic          is_digit;
    rlc_pkg::seg_t seg_prev, seg_cur, seg_none;

    always_comb begin
        same_run = holding_reg && (item.symbol == held_symbol_reg) &&
                   (run_length_reg < CW'(MAX_RUN));
        is_digit = (item.symbol >= rlc_pkg::DIGIT_BASE) &&
                   (item.symbol <= rlc_pkg::DIGIT_TOP);

        held_symbol_next   = held_symbol_reg;
        run_length_next    = run_length_reg;
        holding_next       = holding_reg;
        repeat_count_next  = repeat_count_reg;
        count_pending_next = count_pending_reg;

        seg_none = '0;
        seg_prev = '0;
        seg_cur  = '0;
        cmd      = '0;
        push     = 1'b0;

        // closing segment of the open run
        seg_prev.valid    = 1'b1;
        seg_prev.digit_en = run_length_reg > CW'(1);
        seg_prev.digit    = run_length_reg;
        seg_prev.sym      = held_symbol_reg;
        seg_prev.reps     = CW'(1);

        if (!item.decode_mode) begin
            if (same_run) begin
                run_length_next = run_length_reg + CW'(1);
            end else begin
                held_symbol_next = item.symbol;
                run_length_next  = CW'(1);
                holding_next     = 1'b1;
            end
            seg_cur.valid    = 1'b1;
            seg_cur.digit_en = run_length_next > CW'(1);
            seg_cur.digit    = run_length_next;
            seg_cur.sym      = held_symbol_next;
            seg_cur.reps     = CW'(1);

            cmd.last = item.end_of_string;
            if (holding_reg && !same_run) begin
                push      = 1'b1;
                cmd.seg_a = seg_prev;
                cmd.seg_b = item.end_of_string ? seg_cur : seg_none;
            end else if (item.end_of_string) begin
                push      = 1'b1;
                cmd.seg_a = seg_cur;
            end
        end else begin
            cmd.last = item.end_of_string;
            cmd.seg_a.valid = 1'b1;
            cmd.seg_a.sym   = item.symbol;
            if (count_pending_reg) begin
                cmd.seg_a.reps     = repeat_count_reg;
                push               = repeat_count_reg != '0;
                count_pending_next = 1'b0;
                repeat_count_next  = '0;
            end else if (is_digit) begin
                repeat_count_next  = CW'(item.symbol - rlc_pkg::DIGIT_BASE);
                count_pending_next = 1'b1;
            end else begin
                cmd.seg_a.reps = CW'(1);
                push           = 1'b1;
            end
        end

        // end of string clears both modes
        if (item.end_of_string) begin
            held_symbol_next   = '0;
            run_length_next    = '0;
            holding_next       = 1'b0;
            repeat_count_next  = '0;
            count_pending_next = 1'b0;
        end

        if (!fire) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_symbol_reg   <= '0;
            run_length_reg    <= '0;
            holding_reg       <= 1'b0;
            repeat_count_reg  <= '0;
            count_pending_reg <= 1'b0;
        end else if (fire) begin
            held_symbol_reg   <= held_symbol_next;
            run_length_reg    <= run_length_next;
            holding_reg       <= holding_next;
            repeat_count_reg  <= repeat_count_next;
            count_pending_reg <= count_pending_next;
        end
    end

endmodule

FILE: sv/rlc_cmd_fifo.sv
// rlc_cmd_fifo: short command queue between front and back end
// register array with wrap-around pointers and a fill count
// depends on rlc_pkg
module rlc_cmd_fifo #(
    parameter int DEPTH = rlc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rlc_pkg::cmd_t push_data,
    input  logic          pop,
    output rlc_pkg::cmd_t head,
    output logic          not_empty,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    rlc_pkg::cmd_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    always_comb begin
        full      = fill_reg == FILL_W'(DEPTH);
        not_empty = fill_reg != '0;
        head      = entries_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/rlc_back.sv
// rlc_back: expands queued commands into output bytes, one per cycle
// while m_ready allows; drives the registered result channel
// depends on rlc_pkg
module rlc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  rlc_pkg::cmd_t      head,
    input  logic               head_valid,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output rlc_pkg::out_item_t m_item
);

    localparam int CW = rlc_pkg::CNT_W;

    logic               m_valid_reg, m_valid_next;
    rlc_pkg::out_item_t m_item_reg, m_item_next;
    logic               seg_sel_reg, seg_sel_next;
    logic               digit_done_reg, digit_done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    rlc_pkg::seg_t seg;
    logic          advance, emit;

    always_comb begin
        seg     = seg_sel_reg ? head.seg_b : head.seg_a;
        advance = !m_valid_reg || m_ready;
        emit    = advance && head_valid;

        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        seg_sel_next    = seg_sel_reg;
        digit_done_next = digit_done_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;

        if (emit) begin
            m_valid_next = 1'b1;
            if (seg.digit_en && !digit_done_reg) begin
                // count digit ahead of the symbol
                m_item_next.out_symbol = rlc_pkg::DIGIT_BASE + 8'(seg.digit);
                m_item_next.out_last   = 1'b0;
                digit_done_next        = 1'b1;
            end else begin
                m_item_next.out_symbol = seg.sym;
                m_item_next.out_last   = 1'b0;
                cnt_next               = cnt_reg + CW'(1);
                if (cnt_next == seg.reps) begin
                    cnt_next        = '0;
                    digit_done_next = 1'b0;
                    if (!seg_sel_reg && head.seg_b.valid) begin
                        seg_sel_next = 1'b1;
                    end else begin
                        seg_sel_next         = 1'b0;
                        pop                  = 1'b1;
                        m_item_next.out_last = head.last;
                    end
                end
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            seg_sel_reg    <= 1'b0;
            digit_done_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            m_valid_reg    <= m_valid_next;
            seg_sel_reg    <= seg_sel_next;
            digit_done_reg <= digit_done_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: sv/run_length_codec_core.sv
// run_length_codec_core: streaming run-length encoder / decoder, single-digit counts
// top level: front end, command queue and back end
// depends on rlc_pkg, rlc_front, rlc_cmd_fifo, rlc_back
//
// usage
//   input channel s_valid / s_ready / s_item: one byte per item, with the mode bit
//   (0 encode, 1 decode) and the end-of-string flag
//   result channel m_valid / m_ready / m_item: one output byte per item, out_last
//   set on the final byte of a transformed string
//   encode: a run becomes an ascii count digit (only for runs longer than one)
//   and the byte; runs longer than MAX_RUN are split
//   decode: a digit is held, the next byte is repeated that many times
//   throughput: one input item per cycle while the queue has room; the back end
//   emits one byte per cycle unless m_ready stalls it, so an item that yields k
//   bytes keeps it busy until all k are out, and the queue of QUEUE_DEPTH commands
//   absorbs that before s_ready drops; bytes leave via the m_item output register
//   reset: synchronous aresetn low empties the queue and clears run and digit state
//   receiver stall: m_ready low holds the output register; the queue fills and
//   then s_ready goes low, nothing is lost
module run_length_codec_core #(
    parameter int MAX_RUN     = rlc_pkg::MAX_RUN_DEFAULT,
    parameter int QUEUE_DEPTH = rlc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rlc_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rlc_pkg::out_item_t m_item
);

    logic          fire;
    logic          push;
    rlc_pkg::cmd_t push_cmd;
    rlc_pkg::cmd_t head;
    logic          head_valid;
    logic          pop;
    logic          q_full;

    // the front end takes an item whenever the queue has a free slot
    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;

    // classify the item and keep run / digit state
    rlc_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (s_item),
        .push    (push),
        .cmd     (push_cmd)
    );

    // decouples input acceptance from output expansion
    rlc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    // expand commands into bytes behind the output register
    rlc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for run_length_codec_core, encode and decode strings
// predicts every output byte in-bench and checks it in order; depends on rlc_pkg
module testbench;

    localparam int RUN_LIMIT    = rlc_pkg::MAX_RUN_DEFAULT;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int DRAIN_BOUND  = 4000;
    localparam int RANDOM_ITEMS = 120;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rlc_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rlc_pkg::out_item_t m_item;

    // bench copy of the codec state
    logic [7:0] enc_sym;
    logic [3:0] enc_len;
    logic       enc_open;
    logic [3:0] dec_reps;
    logic       dec_pending;

    rlc_pkg::out_item_t expected_bytes[$];
    rlc_pkg::in_item_t  string_items[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    run_length_codec_core #(
        .MAX_RUN(RUN_LIMIT)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // run guard, ends a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // prediction of the output byte stream
    // ---------------------------------------------------------------
    task automatic push_expected(input logic [7:0] b, input logic fin);
        rlc_pkg::out_item_t o;
        o.out_symbol = b;
        o.out_last   = fin;
        expected_bytes = {expected_bytes, o};
    endtask

    task automatic clear_codec_state();
        enc_sym     = '0;
        enc_len     = '0;
        enc_open    = 1'b0;
        dec_reps    = '0;
        dec_pending = 1'b0;
    endtask

    // close the open encode run: count digit only for runs longer than one
    task automatic flush_open_run(input logic fin);
        if (enc_len > 4'd1)
            push_expected(rlc_pkg::DIGIT_BASE + {4'd0, enc_len}, 1'b0);
        push_expected(enc_sym, fin);
    endtask

    task automatic predict_codec(input rlc_pkg::in_item_t it);
        int k;
        if (!it.decode_mode) begin
            if (enc_open && it.symbol == enc_sym && enc_len < RUN_LIMIT) begin
                enc_len = enc_len + 4'd1;
            end else begin
                // run change, or the run is full and a new one opens
                if (enc_open)
                    flush_open_run(1'b0);
                enc_sym  = it.symbol;
                enc_len  = 4'd1;
                enc_open = 1'b1;
            end
            if (it.end_of_string) begin
                flush_open_run(1'b1);
                clear_codec_state();
            end
        end else begin
            if (dec_pending) begin
                // byte after a digit is repeated literally, digit or not
                for (k = 0; k < dec_reps && k < 9; k++)
                    push_expected(it.symbol, it.end_of_string && (k + 1 == dec_reps));
                dec_pending = 1'b0;
                dec_reps    = '0;
            end else if (it.symbol >= rlc_pkg::DIGIT_BASE &&
                         it.symbol <= rlc_pkg::DIGIT_TOP) begin
                dec_reps    = 4'(it.symbol - rlc_pkg::DIGIT_BASE);
                dec_pending = 1'b1;
            end else begin
                push_expected(it.symbol, it.end_of_string);
            end
            if (it.end_of_string)
                clear_codec_state();
        end
    endtask

    // ---------------------------------------------------------------
    // sender: bursts of random length with random gaps in between
    // ---------------------------------------------------------------
    function automatic rlc_pkg::in_item_t make_item(input logic [7:0] b, input logic dec,
                                                    input logic fin);
        rlc_pkg::in_item_t it;
        it.symbol        = b;
        it.decode_mode   = dec;
        it.end_of_string = fin;
        return it;
    endfunction

    task automatic send_item(input rlc_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_codec(it);
        burst_left--;
    endtask

    task automatic send_string_items();
        foreach (string_items[i])
            send_item(string_items[i]);
    endtask

    task automatic append_item(input rlc_pkg::in_item_t it);
        string_items = {string_items, it};
    endtask

    // ---------------------------------------------------------------
    // receiver: stall styles drawn at random, each kept until its countdown runs out
    // ---------------------------------------------------------------
    int stall_style = 0;
    int stall_left  = 0;

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(10, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= cycle_count[2];
        endcase
    end

    // ---------------------------------------------------------------
    // checker: each accepted output byte against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        rlc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %b",
                                          m_item.out_symbol, m_item.out_last));
            end else begin
                want = expected_bytes.pop_front();
                if (m_item.out_symbol !== want.out_symbol)
                    report_mismatch($sformatf("out_symbol %02h, want %02h",
                                              m_item.out_symbol, want.out_symbol));
                if (m_item.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last %b, want %b on byte %02h",
                                              m_item.out_last, want.out_last,
                                              want.out_symbol));
            end
        end
    end

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------
    // a one-byte string passes straight through, zero byte as extreme
    task automatic test_single_byte();
        send_item(make_item(8'h00, 1'b0, 1'b1));
    endtask

    task automatic test_encode_runs();
        send_item(make_item("A", 1'b0, 1'b0));
        send_item(make_item("A", 1'b0, 1'b0));
        send_item(make_item("B", 1'b0, 1'b1));
    endtask

    // ten equal bytes: the run splits at the limit
    task automatic test_long_run();
        int k;
        for (k = 0; k < 10; k++)
            send_item(make_item("C", 1'b0, k == 9));
    endtask

    // digits are plain bytes when encoding
    task automatic test_encode_digits();
        send_item(make_item("5", 1'b0, 1'b0));
        send_item(make_item("5", 1'b0, 1'b1));
    endtask

    task automatic test_decode_expand();
        send_item(make_item(8'hFF, 1'b1, 1'b1));
        send_item(make_item("3", 1'b1, 1'b0));
        send_item(make_item("X", 1'b1, 1'b1));
    endtask

    // a digit ending the string yields nothing
    task automatic test_trailing_digit();
        send_item(make_item("7", 1'b1, 1'b1));
    endtask

    // zero count swallows the symbol, no byte carries out_last
    task automatic test_zero_count();
        send_item(make_item("0", 1'b1, 1'b0));
        send_item(make_item("Q", 1'b1, 1'b1));
    endtask

    task automatic test_digit_after_digit();
        send_item(make_item("2", 1'b1, 1'b0));
        send_item(make_item("4", 1'b1, 1'b0));
        send_item(make_item("Z", 1'b1, 1'b1));
    endtask

    // ---------------------------------------------------------------
    // random strings
    // ---------------------------------------------------------------
    function automatic logic [7:0] random_symbol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return 8'("A" + $urandom_range(0, 5));
        else if (r == 8)
            return 8'(rlc_pkg::DIGIT_BASE + $urandom_range(0, 9));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(rlc_pkg::DIGIT_BASE + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    task automatic build_encode_string();
        int len;
        int repeat_pct;
        int k;
        logic [7:0] cur;
        string_items.delete();
        if ($urandom_range(0, 7) == 0) begin
            // long runs to hit the split
            len        = $urandom_range(10, 20);
            repeat_pct = 95;
        end else begin
            len        = $urandom_range(1, 12);
            repeat_pct = 55;
        end
        cur = random_symbol();
        for (k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 99) >= repeat_pct)
                cur = random_symbol();
            append_item(make_item(cur, 1'b0, 1'b0));
        end
        string_items[string_items.size() - 1].end_of_string = 1'b1;
    endtask

    task automatic build_decode_string();
        int units;
        int r;
        int k;
        string_items.delete();
        units = $urandom_range(1, 5);
        for (k = 0; k < units; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // well-formed count and symbol
                append_item(make_item(random_digit(), 1'b1, 1'b0));
                append_item(make_item(random_letter(), 1'b1, 1'b0));
            end else if (r < 75) begin
                append_item(make_item(random_letter(), 1'b1, 1'b0));
            end else if (r < 85) begin
                append_item(make_item(random_digit(), 1'b1, 1'b0));
                append_item(make_item(random_digit(), 1'b1, 1'b0));
            end else if (r < 93) begin
                append_item(make_item(8'($urandom_range(0, 255)), 1'b1, 1'b0));
            end else begin
                // mode flips inside the string, encode state is kept apart
                append_item(make_item(random_symbol(), 1'b0, 1'b0));
            end
        end
        if ($urandom_range(0, 9) == 0)
            append_item(make_item(random_digit(), 1'b1, 1'b0));
        string_items[string_items.size() - 1].end_of_string = 1'b1;
    endtask

    task automatic test_random_strings();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0)
                build_encode_string();
            else
                build_decode_string();
            sent += string_items.size();
            send_string_items();
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin : run_tests
        int waited;
        clear_codec_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_byte();
        test_encode_runs();
        test_long_run();
        test_encode_digits();
        test_decode_expand();
        test_trailing_digit();
        test_zero_count();
        test_digit_after_digit();
        test_random_strings();

        s_valid <= 1'b0;
        waited = 0;
        while (expected_bytes.size() != 0 && waited < DRAIN_BOUND) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d predicted bytes never arrived",
                                      expected_bytes.size()));
        // catch stray bytes after the last prediction
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
